// ===== design/pngrf_pkg.sv =====
`timescale 1ns / 1ps

package pngrf_pkg;

   localparam int MAX_BPP_DEFAULT = 4;
   localparam int DATA_W          = 8;
   localparam int BPP_W           = 3;
   localparam int SUM_W           = 22;
   localparam int FILTER_W        = 3;
   localparam int NUM_FILTERS     = 5;
   localparam int MID_DEPTH       = 2;
   localparam int OUT_DEPTH       = 4;
   localparam int OUT_CNT_W       = $clog2(OUT_DEPTH + 1);

   typedef enum logic [FILTER_W-1:0] {
      FILTER_NONE    = 3'd0,
      FILTER_SUB     = 3'd1,
      FILTER_UP      = 3'd2,
      FILTER_AVERAGE = 3'd3,
      FILTER_PAETH   = 3'd4
   } filter_type;

   typedef struct packed {
      logic [DATA_W-1:0] here_byte;
      logic [DATA_W-1:0] above_byte;
      logic              above_valid;
      logic              last_byte;
   } req_type;

   typedef struct packed {
      filter_type       best_filter;
      logic [SUM_W-1:0] best_sum;
   } rsp_type;

   // request with its neighbors resolved
   typedef struct packed {
      logic [DATA_W-1:0] here;
      logic [DATA_W-1:0] left;
      logic [DATA_W-1:0] above;
      logic [DATA_W-1:0] diag;
      logic              last;
   } work_type;

endpackage

// ===== design/pngrf_fifo.sv =====
`timescale 1ns / 1ps

module pngrf_fifo #(
   parameter int DEPTH = 2,
   parameter int WIDTH = 8,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty,
   output logic [CNT_W-1:0] count
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/pngrf_front.sv =====
`timescale 1ns / 1ps

module pngrf_front
   import pngrf_pkg::*;
#(
   parameter int MAX_BPP = MAX_BPP_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_en,
   input  logic [BPP_W-1:0] csr_write_data,
   input  logic             req_push,
   input  req_type          req_data,
   input  logic             mid_full,
   output logic             mid_push,
   output work_type         mid_data
);

   localparam int IDX_W = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;
   localparam int CNT_W = $clog2(MAX_BPP + 1);
   localparam int CMP_W = BPP_W + 1;

   logic [BPP_W-1:0]  bpp_ff;
   logic [DATA_W-1:0] row_hist_ff   [MAX_BPP];
   logic [DATA_W-1:0] above_hist_ff [MAX_BPP];
   logic [CNT_W-1:0]  seen_ff, seen_in;
   logic [CMP_W-1:0]  bpp_wide, stride_wide;
   logic [CNT_W-1:0]  stride;
   logic [IDX_W-1:0]  tap;
   logic              have_left;
   logic              accept;

   assign accept   = req_push & ~mid_full;
   assign mid_push = accept;

   // stride clamped to 1..MAX_BPP
   always_comb begin
      bpp_wide = {1'b0, bpp_ff};
      if (bpp_ff == '0) begin
         stride_wide = CMP_W'(1);
      end else if (bpp_wide > CMP_W'(MAX_BPP)) begin
         stride_wide = CMP_W'(MAX_BPP);
      end else begin
         stride_wide = bpp_wide;
      end
      stride    = CNT_W'(stride_wide);
      tap       = IDX_W'(stride - 1'b1);
      have_left = (seen_ff >= stride);
   end

   always_comb begin
      mid_data.here  = req_data.here_byte;
      mid_data.last  = req_data.last_byte;
      mid_data.above = req_data.above_valid ? req_data.above_byte : '0;
      mid_data.left  = have_left ? row_hist_ff[tap] : '0;
      mid_data.diag  = (have_left && req_data.above_valid) ? above_hist_ff[tap] : '0;
   end

   always_comb begin
      seen_in = seen_ff;
      if (req_data.last_byte) begin
         seen_in = '0;
      end else if (seen_ff < CNT_W'(MAX_BPP)) begin
         seen_in = seen_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff  <= BPP_W'(1);
         seen_ff <= '0;
      end else begin
         if (csr_write_en) begin
            bpp_ff <= csr_write_data;
         end
         if (accept) begin
            seen_ff <= seen_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         row_hist_ff[0]   <= req_data.here_byte;
         above_hist_ff[0] <= req_data.above_byte;
         for (int i = 1; i < MAX_BPP; i++) begin
            row_hist_ff[i]   <= row_hist_ff[i-1];
            above_hist_ff[i] <= above_hist_ff[i-1];
         end
      end
   end

endmodule

// ===== design/pngrf_back.sv =====
`timescale 1ns / 1ps

module pngrf_back
   import pngrf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 mid_empty,
   input  work_type             mid_data,
   output logic                 mid_pop,
   input  logic [OUT_CNT_W-1:0] out_count,
   output logic                 out_push,
   output rsp_type              out_data
);

   localparam int PEND_W = OUT_CNT_W + 1;

   function automatic logic [DATA_W-1:0] magnitude(input logic [DATA_W-1:0] v);
      return v[DATA_W-1] ? DATA_W'(~v + 1'b1) : v;
   endfunction

   function automatic logic [DATA_W-1:0] paeth(input logic [DATA_W-1:0] left,
                                               input logic [DATA_W-1:0] above,
                                               input logic [DATA_W-1:0] diag);
      logic signed [DATA_W:0]   p_up, p_lf;
      logic signed [DATA_W+1:0] p_sum;
      logic [DATA_W:0]          pa, pb, pc;
      p_up  = $signed({1'b0, above}) - $signed({1'b0, diag});
      p_lf  = $signed({1'b0, left}) - $signed({1'b0, diag});
      p_sum = $signed({p_up[DATA_W], p_up}) + $signed({p_lf[DATA_W], p_lf});
      pa    = p_up[DATA_W] ? (DATA_W+1)'(-p_up) : p_up;
      pb    = p_lf[DATA_W] ? (DATA_W+1)'(-p_lf) : p_lf;
      pc    = p_sum[DATA_W+1] ? (DATA_W+1)'(-p_sum) : (DATA_W+1)'(p_sum);
      if (pa <= pb && {1'b0, pa} <= {1'b0, pc}) begin
         return left;
      end else if ({1'b0, pb} <= {1'b0, pc}) begin
         return above;
      end
      return diag;
   endfunction

   logic [DATA_W-1:0] mag_in [NUM_FILTERS];
   logic [DATA_W-1:0] mag_ff [NUM_FILTERS];
   logic              s1_valid_ff, s1_last_ff;
   logic [SUM_W-1:0]  sums_ff [NUM_FILTERS];
   logic [SUM_W-1:0]  sums_in [NUM_FILTERS];
   logic [SUM_W-1:0]  upd     [NUM_FILTERS];
   logic [SUM_W-1:0]  fin_ff  [NUM_FILTERS];
   logic              fin_valid_ff;
   logic [PEND_W-1:0] pending;
   logic [DATA_W:0]   avg_sum;
   logic [DATA_W-1:0] avg_pred, paeth_pred;
   filter_type        pick01, pick23, pick03, pick_all;
   logic [SUM_W-1:0]  v01, v23, v03;

   // results in flight each need a free output slot
   assign pending = PEND_W'(s1_valid_ff & s1_last_ff) + PEND_W'(fin_valid_ff)
                    + PEND_W'(out_count);
   assign mid_pop = ~mid_empty & (pending < PEND_W'(OUT_DEPTH));

   // residual magnitudes
   always_comb begin
      avg_sum    = {1'b0, mid_data.left} + {1'b0, mid_data.above};
      avg_pred   = avg_sum[DATA_W:1];
      paeth_pred = paeth(mid_data.left, mid_data.above, mid_data.diag);
      mag_in[FILTER_NONE]    = magnitude(mid_data.here);
      mag_in[FILTER_SUB]     = magnitude(mid_data.here - mid_data.left);
      mag_in[FILTER_UP]      = magnitude(mid_data.here - mid_data.above);
      mag_in[FILTER_AVERAGE] = magnitude(mid_data.here - avg_pred);
      mag_in[FILTER_PAETH]   = magnitude(mid_data.here - paeth_pred);
   end

   // saturating accumulate
   always_comb begin
      logic [SUM_W:0] total;
      for (int k = 0; k < NUM_FILTERS; k++) begin
         total      = {1'b0, sums_ff[k]} + (SUM_W+1)'(mag_ff[k]);
         upd[k]     = total[SUM_W] ? '1 : total[SUM_W-1:0];
         sums_in[k] = s1_last_ff ? '0 : upd[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fin_valid_ff <= 1'b0;
         for (int k = 0; k < NUM_FILTERS; k++) begin
            sums_ff[k] <= '0;
         end
      end else begin
         s1_valid_ff  <= mid_pop;
         fin_valid_ff <= s1_valid_ff & s1_last_ff;
         if (s1_valid_ff) begin
            for (int k = 0; k < NUM_FILTERS; k++) begin
               sums_ff[k] <= sums_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mid_pop) begin
         s1_last_ff <= mid_data.last;
         for (int k = 0; k < NUM_FILTERS; k++) begin
            mag_ff[k] <= mag_in[k];
         end
      end
      if (s1_valid_ff && s1_last_ff) begin
         for (int k = 0; k < NUM_FILTERS; k++) begin
            fin_ff[k] <= upd[k];
         end
      end
   end

   // minimum, lower code wins a tie
   always_comb begin
      pick01 = (fin_ff[FILTER_SUB] < fin_ff[FILTER_NONE]) ? FILTER_SUB : FILTER_NONE;
      v01    = (pick01 == FILTER_SUB) ? fin_ff[FILTER_SUB] : fin_ff[FILTER_NONE];
      pick23 = (fin_ff[FILTER_AVERAGE] < fin_ff[FILTER_UP]) ? FILTER_AVERAGE : FILTER_UP;
      v23    = (pick23 == FILTER_AVERAGE) ? fin_ff[FILTER_AVERAGE] : fin_ff[FILTER_UP];
      pick03 = (v23 < v01) ? pick23 : pick01;
      v03    = (v23 < v01) ? v23 : v01;
      pick_all = (fin_ff[FILTER_PAETH] < v03) ? FILTER_PAETH : pick03;
      out_data.best_filter = pick_all;
      out_data.best_sum    = (pick_all == FILTER_PAETH) ? fin_ff[FILTER_PAETH] : v03;
   end

   assign out_push = fin_valid_ff;

endmodule

// ===== design/png_row_filter_selector.sv =====
`timescale 1ns / 1ps

// png row filter selector: scores each scanline byte against the none, sub,
// up, average and paeth predictors and reports the filter with the smallest
// sum of residual magnitudes once per row.
// request side: present req_data with req_push; taken when req_full is low.
// set last_byte on the final byte of a row; only that byte yields a response.
// response side: while rsp_empty is low, rsp_data holds the oldest result;
// assert rsp_pop to take it.
// csr_write_en with csr_write_data sets the pixel stride (0 acts as 1,
// values above MAX_BPP act as MAX_BPP); write only while the block is idle.
// throughput: one request per cycle while req_full is low; the front stage
// resolves neighbors from the pixel delay line, the back stage scores through
// a residual magnitude register and a final sum register; a row's response
// goes through the mid queue, those registers and the output queue.
// when rsp_pop stays low, up to four responses are held, then the back stage
// stops and the two-entry queue between the stages fills and raises req_full.
// reset clears both queues, the running sums, the byte count and sets the
// stride to 1.
module png_row_filter_selector
   import pngrf_pkg::*;
#(
   parameter int MAX_BPP = MAX_BPP_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_en,
   input  logic [BPP_W-1:0] csr_write_data,
   input  logic             req_push,
   input  req_type          req_data,
   output logic             req_full,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output rsp_type          rsp_data
);

   localparam int WORK_W = $bits(work_type);
   localparam int RSP_W  = $bits(rsp_type);

   logic                 mid_push, mid_full, mid_pop, mid_empty;
   work_type             mid_wr_data, mid_rd_data;
   logic [WORK_W-1:0]    mid_rd_bits;
   logic                 out_push;
   rsp_type              out_wr_data;
   logic [RSP_W-1:0]     out_rd_bits;
   logic [OUT_CNT_W-1:0] out_count;

   assign req_full    = mid_full;
   assign mid_rd_data = work_type'(mid_rd_bits);
   assign rsp_data    = rsp_type'(out_rd_bits);

   pngrf_front #(
      .MAX_BPP (MAX_BPP)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_push       (req_push),
      .req_data       (req_data),
      .mid_full       (mid_full),
      .mid_push       (mid_push),
      .mid_data       (mid_wr_data)
   );

   pngrf_fifo #(
      .DEPTH (MID_DEPTH),
      .WIDTH (WORK_W)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_wr_data),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_rd_bits),
      .empty     (mid_empty),
      .count     ()
   );

   pngrf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .mid_data  (mid_rd_data),
      .mid_pop   (mid_pop),
      .out_count (out_count),
      .out_push  (out_push),
      .out_data  (out_wr_data)
   );

   pngrf_fifo #(
      .DEPTH (OUT_DEPTH),
      .WIDTH (RSP_W)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_wr_data),
      .full      (),
      .pop       (rsp_pop),
      .pop_data  (out_rd_bits),
      .empty     (rsp_empty),
      .count     (out_count)
   );

endmodule
